// ----- rtl/core/rled_pkg.sv -----
// ----------------------------------------------------------------------------
// rled_pkg: shared types and constants for the RLE pixel stream decoder
// Controller state, command and status bundles, result field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package rled_pkg;

    localparam int PIX_W     = 24;
    localparam int PIX_LANES = 3;
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 3;
    localparam int GROUP_MAX = 4;
    localparam int TDATA_W   = 104;   // 4*24 + 3 = 99 bits, padded to whole bytes

    typedef enum logic [1:0] {
        ST_HEADER,
        ST_COUNT,
        ST_PIXEL,
        ST_REPEAT
    } rled_state_t;

    typedef struct packed {
        logic load_run;     // header was a repeat count
        logic load_count;   // literal count byte, nonzero
        logic take_byte;    // pixel byte accepted
        logic emit_lit;     // finished literal pixel goes out
        logic emit_first;   // finished repeat pixel, first group
        logic emit_next;    // following repeat group
    } rled_cmd_t;

    typedef struct packed {
        logic byte_zero;    // incoming byte is zero
        logic pixel_done;   // incoming byte is the final byte of a pixel
        logic lit_last;     // current literal pixel is the last of its run
        logic rep_last;     // the group being issued ends the repeat run
        logic out_free;     // output register can take a new result
    } rled_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/rle_pixel_stream_decoder_core.sv -----
// Latency: a result is presented the cycle after the final byte of a pixel is accepted.
// Throughput: one input byte per cycle, except after a repeat pixel, which issues
// ceil(count/4) results at one per cycle (up to 64); the first goes out with the
// final pixel byte and the input is held off for the rest.
// Output register stalls input only while a result is waiting and m_tready is low.
// Reset: synchronous active-low aresetn clears the state machine, counters and
// output valid; pixel payload registers are not reset.
// ----------------------------------------------------------------------------
// rle_pixel_stream_decoder_core: run-length pixel stream decoder
// Decodes repeat and literal runs into groups of up to four pixels per result.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_pixel_stream_decoder_core #(
    parameter int PIXEL_BYTES = 3
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // tdata: in_byte[7:0]
    input  wire  [7:0]                       s_tdata,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // tdata: pixel_a[23:0], pixel_b[47:24], pixel_c[71:48], pixel_d[95:72],
    //        group_count[98:96], zero pad[103:99]
    output logic [rled_pkg::TDATA_W-1:0]     m_tdata,
    output logic                             m_tlast
);

    rled_pkg::rled_cmd_t    cmd;
    rled_pkg::rled_status_t status;

    rled_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rled_dp #(
        .PIXEL_BYTES (PIXEL_BYTES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_byte  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ----- rtl/core/rled_ctrl.sv -----
// ----------------------------------------------------------------------------
// rled_ctrl: token state machine
// Tracks header / count / pixel / repeat phases and drives datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module rled_ctrl (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  rled_pkg::rled_status_t status,
    output rled_pkg::rled_cmd_t   cmd
);

    rled_pkg::rled_state_t state_reg, state_next;
    logic                  lit_mode_reg, lit_mode_next;
    logic                  acc;

    assign s_tready = status.out_free && (state_reg != rled_pkg::ST_REPEAT);
    assign acc      = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= rled_pkg::ST_HEADER;
            lit_mode_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            lit_mode_reg <= lit_mode_next;
        end
    end

    // next state
    always_comb begin
        state_next    = state_reg;
        lit_mode_next = lit_mode_reg;
        unique case (state_reg)
            rled_pkg::ST_HEADER: begin
                if (acc) begin
                    lit_mode_next = status.byte_zero;
                    state_next    = status.byte_zero ? rled_pkg::ST_COUNT
                                                     : rled_pkg::ST_PIXEL;
                end
            end
            rled_pkg::ST_COUNT: begin
                if (acc) begin
                    state_next = status.byte_zero ? rled_pkg::ST_HEADER
                                                  : rled_pkg::ST_PIXEL;
                end
            end
            rled_pkg::ST_PIXEL: begin
                if (acc && status.pixel_done) begin
                    if (lit_mode_reg) begin
                        if (status.lit_last) begin
                            state_next = rled_pkg::ST_HEADER;
                        end
                    end else begin
                        state_next = status.rep_last ? rled_pkg::ST_HEADER
                                                     : rled_pkg::ST_REPEAT;
                    end
                end
            end
            rled_pkg::ST_REPEAT: begin
                if (status.out_free && status.rep_last) begin
                    state_next = rled_pkg::ST_HEADER;
                end
            end
            default: state_next = rled_pkg::ST_HEADER;
        endcase
    end

    // commands
    always_comb begin
        cmd = '0;
        unique case (state_reg)
            rled_pkg::ST_HEADER: begin
                cmd.load_run = acc && !status.byte_zero;
            end
            rled_pkg::ST_COUNT: begin
                cmd.load_count = acc && !status.byte_zero;
            end
            rled_pkg::ST_PIXEL: begin
                cmd.take_byte  = acc;
                cmd.emit_lit   = acc && status.pixel_done && lit_mode_reg;
                cmd.emit_first = acc && status.pixel_done && !lit_mode_reg;
            end
            rled_pkg::ST_REPEAT: begin
                cmd.emit_next = status.out_free;
            end
            default: cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/rled_dp.sv -----
// ----------------------------------------------------------------------------
// rled_dp: decoder datapath
// Pixel assembly, run counters and the registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rled_dp #(
    parameter int PIXEL_BYTES = 3
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire  [rled_pkg::BYTE_W-1:0]        in_byte,
    input  rled_pkg::rled_cmd_t                cmd,
    output rled_pkg::rled_status_t             status,
    input  wire                                m_tready,
    output logic                               m_tvalid,
    // tdata: pixel_a[23:0], pixel_b[47:24], pixel_c[71:48], pixel_d[95:72],
    //        group_count[98:96], zero pad[103:99]
    output logic [rled_pkg::TDATA_W-1:0]       m_tdata,
    output logic                               m_tlast
);

    localparam int IDX_W = (PIXEL_BYTES > 1) ? $clog2(PIXEL_BYTES) : 1;
    localparam int PAD_W = rled_pkg::TDATA_W - 4 * rled_pkg::PIX_W - rled_pkg::CNT_W;

    logic [IDX_W-1:0]                 byte_idx_reg, byte_idx_next;
    logic [rled_pkg::PIX_W-1:0]       accum_reg, accum_next;
    logic [rled_pkg::BYTE_W-1:0]      lit_left_reg, lit_left_next;
    logic [rled_pkg::BYTE_W-1:0]      run_left_reg, run_left_next;
    logic [rled_pkg::PIX_W-1:0]       out_pix_reg, out_pix_next;
    logic [rled_pkg::CNT_W-1:0]       out_cnt_reg, out_cnt_next;
    logic                             out_last_reg, out_last_next;
    logic                             out_valid_reg, out_valid_next;

    logic [rled_pkg::PIX_W-1:0]       merged;
    logic [rled_pkg::CNT_W-1:0]       grp_n;
    logic                             pixel_done;
    logic                             start_pixel;

    // place the incoming byte into its lane; lanes above the third are dropped
    always_comb begin
        merged = accum_reg;
        for (int i = 0; i < rled_pkg::PIX_LANES; i++) begin
            if (int'(byte_idx_reg) == i) begin
                merged[i*rled_pkg::BYTE_W +: rled_pkg::BYTE_W] = in_byte;
            end
        end
    end

    assign pixel_done  = (int'(byte_idx_reg) == PIXEL_BYTES - 1);
    assign start_pixel = cmd.load_run || cmd.load_count || (cmd.take_byte && pixel_done);
    assign grp_n       = (run_left_reg > rled_pkg::BYTE_W'(rled_pkg::GROUP_MAX))
                         ? rled_pkg::CNT_W'(rled_pkg::GROUP_MAX)
                         : run_left_reg[rled_pkg::CNT_W-1:0];

    assign status.byte_zero  = (in_byte == '0);
    assign status.pixel_done = pixel_done;
    assign status.lit_last   = (lit_left_reg == rled_pkg::BYTE_W'(1));
    assign status.rep_last   = (run_left_reg <= rled_pkg::BYTE_W'(rled_pkg::GROUP_MAX));
    assign status.out_free   = !out_valid_reg || m_tready;

    always_comb begin
        byte_idx_next  = byte_idx_reg;
        accum_next     = accum_reg;
        lit_left_next  = lit_left_reg;
        run_left_next  = run_left_reg;
        out_pix_next   = out_pix_reg;
        out_cnt_next   = out_cnt_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;

        if (start_pixel) begin
            byte_idx_next = '0;
            accum_next    = '0;
        end else if (cmd.take_byte) begin
            byte_idx_next = byte_idx_reg + 1'b1;
            accum_next    = merged;
        end

        if (cmd.load_run) begin
            run_left_next = in_byte;
        end
        if (cmd.load_count) begin
            lit_left_next = in_byte;
        end

        if (cmd.emit_lit) begin
            out_pix_next   = merged;
            out_cnt_next   = rled_pkg::CNT_W'(1);
            out_last_next  = 1'b1;
            out_valid_next = 1'b1;
            lit_left_next  = lit_left_reg - 1'b1;
        end
        if (cmd.emit_first || cmd.emit_next) begin
            // later groups reuse the pixel still held in the result register
            if (cmd.emit_first) begin
                out_pix_next = merged;
            end
            out_cnt_next   = grp_n;
            out_last_next  = status.rep_last;
            out_valid_next = 1'b1;
            run_left_next  = run_left_reg - rled_pkg::BYTE_W'(grp_n);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_idx_reg  <= '0;
            lit_left_reg  <= '0;
            run_left_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            byte_idx_reg  <= byte_idx_next;
            lit_left_reg  <= lit_left_next;
            run_left_reg  <= run_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        accum_reg    <= accum_next;
        out_pix_reg  <= out_pix_next;
        out_cnt_reg  <= out_cnt_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {
        {PAD_W{1'b0}},
        out_cnt_reg,
        (out_cnt_reg >= rled_pkg::CNT_W'(4)) ? out_pix_reg : '0,
        (out_cnt_reg >= rled_pkg::CNT_W'(3)) ? out_pix_reg : '0,
        (out_cnt_reg >= rled_pkg::CNT_W'(2)) ? out_pix_reg : '0,
        out_pix_reg
    };

endmodule

`default_nettype wire

// ----- rtl/core/rled_checker.sv -----
// ----------------------------------------------------------------------------
// rled_checker: port-level checks for the RLE pixel stream decoder
// Observes top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module rled_checker (
    input wire         aclk,
    input wire         aresetn,
    input wire         s_tvalid,
    input wire         s_tready,
    input wire         m_tvalid,
    input wire         m_tready,
    input wire [103:0] m_tdata,
    input wire         m_tlast
);

    // result register empties on reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[98:96] != 3'd0) && (m_tdata[98:96] <= 3'd4))
        else $error("group count out of range");

    // only the final group of a repeat run may be short
    a_full_group: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[98:96] == 3'd4)
        else $error("short group that is not last");

    a_unused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[98:96] == 3'd1) |-> m_tdata[95:24] == 72'd0)
        else $error("unused pixel fields not zero");

    // a pending result blocks new input
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result stalled");

endmodule

bind rle_pixel_stream_decoder_core rled_checker u_rled_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
